// ----- design/srmt_pkg.sv -----
// Shared types and codes for the sorted range merge table.
`default_nettype none

package srmt_pkg;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Status codes carried on the output tuser.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_IDX  = 2'd2;

    // Field widths.
    localparam int START_W = 31;
    localparam int LEN_IN_W = 31;
    localparam int LEN_W = 32;
    localparam int IDX_W = 6;
    localparam int CNT_OUT_W = 7;
    localparam int END_W = 33;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_WRITE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- design/sorted_range_merge_table_unit.sv -----
// Sorted range merge table: a memory-based table of disjoint ranges with add, read and clear.
//
// Input beats arrive on the s-side stream: tuser carries the operation (add, read,
// clear) and tdata the range start, range length and entry index. Each input beat
// gives exactly one output beat on the m-side stream: tdata carries the start and
// length of a read entry (zero otherwise) and the entry count, tuser the status.
// One operation is worked at a time; o_s_tready is high only while the sequencer idles.
// A read or a clear goes from the accept to the done state, which loads the result
// register and makes the unit ready again once that register is free. An add runs
// a scan that reads one entry per cycle from the table memory (one read port, one
// write port) until the merge window closes, then a shift that moves one entry per
// cycle (read then write back) over only the entries past the window, then one
// write of the merged entry; a full table ends the add early. The table contents
// are not cleared by reset; reset only zeroes the entry count and the control state,
// so the table is empty at once. When the receiver stalls, the finished result waits
// in the output register; the next operation is still accepted and worked, but it
// holds in its final step until the register is free, and the input stays not ready.
`default_nettype none

module sorted_range_merge_table_unit
    import srmt_pkg::*;
#(
    parameter int MAX_RANGES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // range_start [30:0], range_length [61:31], entry_index [67:62], zero pad
    input  wire logic [71:0] i_s_tdata,
    // op [1:0]
    input  wire logic [1:0]  i_s_tuser,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // out_start [30:0], out_length [62:31], entry_count [69:63], zero pad
    output logic [71:0]      o_m_tdata,
    // status [1:0]
    output logic [1:0]       o_m_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready
);

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int MW = START_W + LEN_W;

    // Input field split.
    logic [START_W-1:0]  in_start;
    logic [LEN_IN_W-1:0] in_len;
    logic [IDX_W-1:0]    in_idx;

    assign in_start = i_s_tdata[START_W-1:0];
    assign in_len   = i_s_tdata[START_W+LEN_IN_W-1:START_W];
    assign in_idx   = i_s_tdata[START_W+LEN_IN_W+IDX_W-1:START_W+LEN_IN_W];

    // Control and working registers.
    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [1:0]         r_op, n_op;
    logic [1:0]         r_status, n_status;
    logic               r_found, n_found;
    logic [START_W-1:0] r_lo, n_lo;
    logic [END_W-1:0]   r_hi, n_hi;
    logic [CW-1:0]      r_first, n_first;
    logic [CW-1:0]      r_last, n_last;
    logic [CW-1:0]      r_rd_idx, n_rd_idx;
    logic               r_ev_valid, n_ev_valid;
    logic [CW-1:0]      r_ev_idx, n_ev_idx;
    logic [CW-1:0]      r_src, n_src;
    logic [CW-1:0]      r_left, n_left;
    logic               r_grow, n_grow;
    logic [CW-1:0]      r_gap, n_gap;
    logic [CW-1:0]      r_new_count, n_new_count;
    logic               r_wr_pend, n_wr_pend;
    logic [AW-1:0]      r_wr_addr, n_wr_addr;

    // Output register.
    logic                 r_out_valid, n_out_valid;
    logic [START_W-1:0]   r_out_start, n_out_start;
    logic [LEN_W-1:0]     r_out_length, n_out_length;
    logic [CNT_OUT_W-1:0] r_out_count, n_out_count;
    logic [1:0]           r_out_status, n_out_status;

    // Table memory: length in the upper bits, start in the lower bits.
    logic [MW-1:0] r_mem [MAX_RANGES];
    logic [MW-1:0] r_rdata;
    logic          mem_re;
    logic [AW-1:0] mem_ra;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [MW-1:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    // Scan evaluation of the entry that the memory just returned.
    logic [END_W-1:0] ev_es;
    logic [END_W-1:0] ev_ee;
    logic             ev_hit;
    logic             ev_open;
    logic             ev_touch;
    logic             ev_break;
    logic             ev_end;

    always_comb begin
        ev_es    = {{(END_W-START_W){1'b0}}, r_rdata[START_W-1:0]};
        ev_ee    = ev_es + {1'b0, r_rdata[MW-1:START_W]};
        ev_hit   = !r_found && (ev_ee >= {{(END_W-START_W){1'b0}}, r_lo});
        ev_open  = r_found || ev_hit;
        ev_touch = ev_es <= r_hi;
        ev_break = ev_open && !ev_touch;
        ev_end   = ev_break || (r_ev_idx == r_count - CW'(1));
    end

    // Shift destination for the entry read this cycle.
    logic [CW-1:0] shift_dst;
    logic [CW-1:0] merge_gap;

    assign shift_dst = r_grow ? (r_src + CW'(1)) : (r_src - r_gap);
    assign merge_gap = r_last - r_first - CW'(1);

    // Next state, memory control and working register updates.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_op         = r_op;
        n_status     = r_status;
        n_found      = r_found;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_first      = r_first;
        n_last       = r_last;
        n_rd_idx     = r_rd_idx;
        n_ev_valid   = r_ev_valid;
        n_ev_idx     = r_ev_idx;
        n_src        = r_src;
        n_left       = r_left;
        n_grow       = r_grow;
        n_gap        = r_gap;
        n_new_count  = r_new_count;
        n_wr_pend    = r_wr_pend;
        n_wr_addr    = r_wr_addr;
        n_out_valid  = r_out_valid;
        n_out_start  = r_out_start;
        n_out_length = r_out_length;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        mem_re       = 1'b0;
        mem_ra       = r_rd_idx[AW-1:0];
        mem_we       = 1'b0;
        mem_wa       = r_wr_addr;
        mem_wd       = r_rdata;
        o_s_tready   = (r_state == S_IDLE);

        // The receiver takes the waiting result.
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_op     = i_s_tuser;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                    case (i_s_tuser)
                        OP_ADD: begin
                            n_lo       = in_start;
                            n_hi       = {2'b00, in_start} + {2'b00, in_len};
                            n_found    = 1'b0;
                            n_first    = r_count;
                            n_last     = r_count;
                            n_rd_idx   = '0;
                            n_ev_valid = 1'b0;
                            n_state    = (r_count == '0) ? S_DECIDE : S_SCAN;
                        end
                        OP_READ: begin
                            mem_re = 1'b1;
                            mem_ra = AW'(in_idx);
                            if (!(32'(in_idx) < 32'(r_count) &&
                                  32'(in_idx) < 32'(MAX_RANGES))) begin
                                n_status = ST_BAD_IDX;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Keep one read in flight ahead of the evaluation.
                if (r_rd_idx < r_count) begin
                    mem_re     = 1'b1;
                    mem_ra     = r_rd_idx[AW-1:0];
                    n_rd_idx   = r_rd_idx + CW'(1);
                    n_ev_valid = 1'b1;
                    n_ev_idx   = r_rd_idx;
                end else begin
                    n_ev_valid = 1'b0;
                end
                if (r_ev_valid) begin
                    if (ev_hit) begin
                        n_found = 1'b1;
                        n_first = r_ev_idx;
                        n_last  = r_ev_idx;
                        if (ev_es < {2'b00, r_lo}) begin
                            n_lo = ev_es[START_W-1:0];
                        end
                    end
                    if (ev_open && ev_touch) begin
                        n_last = r_ev_idx + CW'(1);
                        if (ev_ee > r_hi) begin
                            n_hi = ev_ee;
                        end
                    end
                    if (ev_end) begin
                        n_ev_valid = 1'b0;
                        n_state    = S_DECIDE;
                    end
                end
            end

            S_DECIDE: begin
                n_wr_pend = 1'b0;
                if (r_first == r_last) begin
                    // A new entry is needed: open a slot at the first index.
                    if (r_count >= CW'(MAX_RANGES)) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_grow      = 1'b1;
                        n_src       = r_count - CW'(1);
                        n_left      = r_count - r_first;
                        n_new_count = r_count + CW'(1);
                        n_state     = S_SHIFT;
                    end
                end else begin
                    // Entries were merged: pull the tail down over the gap.
                    n_grow      = 1'b0;
                    n_gap       = merge_gap;
                    n_src       = r_last;
                    n_left      = r_count - r_last;
                    n_new_count = r_count - merge_gap;
                    n_state     = S_SHIFT;
                end
            end

            S_SHIFT: begin
                if (r_wr_pend) begin
                    mem_we = 1'b1;
                    mem_wa = r_wr_addr;
                    mem_wd = r_rdata;
                end
                if (r_left != '0) begin
                    mem_re    = 1'b1;
                    mem_ra    = r_src[AW-1:0];
                    n_wr_pend = 1'b1;
                    n_wr_addr = shift_dst[AW-1:0];
                    n_src     = r_grow ? (r_src - CW'(1)) : (r_src + CW'(1));
                    n_left    = r_left - CW'(1);
                end else begin
                    n_wr_pend = 1'b0;
                    if (!r_wr_pend) begin
                        n_state = S_WRITE;
                    end
                end
            end

            S_WRITE: begin
                mem_we  = 1'b1;
                mem_wa  = r_first[AW-1:0];
                mem_wd  = {LEN_W'(r_hi - {2'b00, r_lo}), r_lo};
                n_count = r_new_count;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_count  = CNT_OUT_W'(r_count);
                    n_out_status = r_status;
                    if (r_op == OP_READ && r_status == ST_OK) begin
                        n_out_start  = r_rdata[START_W-1:0];
                        n_out_length = r_rdata[MW-1:START_W];
                    end else begin
                        n_out_start  = '0;
                        n_out_length = '0;
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ev_valid  <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ev_valid  <= n_ev_valid;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_status     <= n_status;
        r_found      <= n_found;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_first      <= n_first;
        r_last       <= n_last;
        r_rd_idx     <= n_rd_idx;
        r_ev_idx     <= n_ev_idx;
        r_src        <= n_src;
        r_left       <= n_left;
        r_grow       <= n_grow;
        r_gap        <= n_gap;
        r_new_count  <= n_new_count;
        r_wr_addr    <= n_wr_addr;
        r_out_start  <= n_out_start;
        r_out_length <= n_out_length;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    // Output beat.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {2'b00, r_out_count, r_out_length, r_out_start};

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the sorted range merge table unit.
`timescale 1ns / 1ps

module testbench;
    import srmt_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int HALF_PERIOD = 4;
    localparam int PRINT_LIMIT = 100;
    localparam int TOTAL_ITEMS = 1050;
    localparam int HOLD_AT_RESULT = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int CALM_FROM = 500;
    localparam int CALM_TO = 750;
    localparam int IDLE_PERCENT = 14;

    // One table command as it travels on the input stream.
    typedef struct {
        logic [1:0]          op;
        logic [START_W-1:0]  start;
        logic [LEN_IN_W-1:0] len;
        logic [IDX_W-1:0]    idx;
        bit                  wait_empty;
    } t_range_cmd;

    // One table response as it travels on the output stream.
    typedef struct {
        logic [START_W-1:0]   start;
        logic [LEN_W-1:0]     len;
        logic [CNT_OUT_W-1:0] count;
        logic [1:0]           status;
    } t_table_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    // range_start [30:0], range_length [61:31], entry_index [67:62], zero pad
    logic [71:0] i_s_tdata = '0;
    // op [1:0]
    logic [1:0]  i_s_tuser = OP_ADD;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // out_start [30:0], out_length [62:31], entry_count [69:63], zero pad
    logic [71:0] o_m_tdata;
    // status [1:0]
    logic [1:0]  o_m_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;

    // Shadow copy of the table used to predict every response.
    logic [START_W-1:0] model_starts [TABLE_DEPTH];
    logic [LEN_W-1:0]   model_lens [TABLE_DEPTH];
    int                 model_count = 0;

    t_range_cmd    pending_cmds[$];
    t_table_result expected_results[$];
    int            n_accepted = 0;
    int            n_results = 0;
    int            mismatches = 0;
    int            hold_left = 0;
    bit            hold_done = 1'b0;
    wire           calm = (n_accepted >= CALM_FROM) && (n_accepted < CALM_TO);

    sorted_range_merge_table_unit #(
        .MAX_RANGES (TABLE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Prints a bounded number of mismatch lines but counts every one.
    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("mismatch @%0t: %s", $realtime, msg);
        end
    endtask

    // Applies one command to the shadow table and returns the response it must give.
    function automatic t_table_result apply_cmd(input t_range_cmd c);
        t_table_result    res;
        logic [END_W-1:0] lo;
        logic [END_W-1:0] hi;
        logic [END_W-1:0] es;
        logic [END_W-1:0] ee;
        int               n;
        int               first;
        int               last;
        int               gap;
        bit               found;
        res = '{default: '0};
        res.status = ST_OK;
        n = model_count;
        case (c.op)
            OP_ADD: begin
                lo = END_W'(c.start);
                hi = END_W'(c.start) + END_W'(c.len);
                first = n;
                last = n;
                found = 1'b0;
                // The first entry reaching the new start opens the merge window; each
                // following entry that starts at or below the running end joins it.
                for (int i = 0; i < n; i++) begin
                    es = END_W'(model_starts[i]);
                    ee = es + END_W'(model_lens[i]);
                    if (!found && ee >= END_W'(c.start)) begin
                        if (es < lo) lo = es;
                        found = 1'b1;
                        first = i;
                        last = i;
                    end
                    if (found) begin
                        if (es <= hi) begin
                            if (ee > hi) hi = ee;
                            last = i + 1;
                        end else begin
                            break;
                        end
                    end
                end
                if (first == last && n >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    if (first == last) begin
                        // Open a slot for a new entry.
                        for (int k = n; k > first; k--) begin
                            model_starts[k] = model_starts[k - 1];
                            model_lens[k] = model_lens[k - 1];
                        end
                        model_count = n + 1;
                    end else begin
                        // Compact the entries swallowed by the merge.
                        gap = last - first - 1;
                        for (int k = last; k < n; k++) begin
                            model_starts[k - gap] = model_starts[k];
                            model_lens[k - gap] = model_lens[k];
                        end
                        model_count = n - gap;
                    end
                    model_starts[first] = lo[START_W-1:0];
                    model_lens[first] = LEN_W'(hi - lo);
                end
            end
            OP_READ: begin
                if (int'(c.idx) < model_count) begin
                    res.start = model_starts[c.idx];
                    res.len = model_lens[c.idx];
                end else begin
                    res.status = ST_BAD_IDX;
                end
            end
            OP_CLEAR: begin
                model_count = 0;
            end
            default: begin
            end
        endcase
        res.count = CNT_OUT_W'(model_count);
        return res;
    endfunction

    task automatic queue_cmd(input logic [1:0] op, input longint s, input longint l,
                             input int idx);
        t_range_cmd c;
        c.op = op;
        c.start = START_W'(s);
        c.len = LEN_IN_W'(l);
        c.idx = IDX_W'(idx);
        c.wait_empty = 1'b0;
        pending_cmds.push_back(c);
    endtask

    task automatic queue_add(input longint s, input longint l);
        queue_cmd(OP_ADD, s, l, $urandom_range(0, 63));
    endtask

    task automatic queue_read(input int idx);
        queue_cmd(OP_READ, $urandom, $urandom, idx);
    endtask

    task automatic queue_clear();
        queue_cmd(OP_CLEAR, $urandom, $urandom, $urandom_range(0, 63));
    endtask

    // Input driver: presents queued commands with random gaps.
    always @(posedge i_clk) begin
        t_range_cmd c;
        bit         offer;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            offer = 1'b0;
            if (pending_cmds.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                // A marked command waits until every earlier response has come back.
                if (!pending_cmds[0].wait_empty || (!i_s_tvalid && n_accepted == n_results)) begin
                    c = pending_cmds.pop_front();
                    i_s_tdata <= {4'b0, c.idx, c.len, c.start};
                    i_s_tuser <= c.op;
                    offer = 1'b1;
                end
            end
            i_s_tvalid <= offer;
        end
    end

    // Output ready: random stalls plus one long hold-off that backs up the input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (!hold_done && n_results == HOLD_AT_RESULT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Monitor: checks each output beat, then predicts for each accepted input beat.
    always @(posedge i_clk) begin
        t_table_result want;
        t_range_cmd    got_cmd;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                n_results <= n_results + 1;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              n_results));
                end else begin
                    want = expected_results.pop_front();
                    if (o_m_tdata[30:0] !== want.start)
                        report_mismatch($sformatf("result %0d start %0h, expected %0h",
                                                  n_results, o_m_tdata[30:0], want.start));
                    if (o_m_tdata[62:31] !== want.len)
                        report_mismatch($sformatf("result %0d length %0h, expected %0h",
                                                  n_results, o_m_tdata[62:31], want.len));
                    if (o_m_tdata[69:63] !== want.count)
                        report_mismatch($sformatf("result %0d count %0d, expected %0d",
                                                  n_results, o_m_tdata[69:63], want.count));
                    if (o_m_tuser !== want.status)
                        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                                  n_results, o_m_tuser, want.status));
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                got_cmd.op = i_s_tuser;
                got_cmd.start = i_s_tdata[30:0];
                got_cmd.len = i_s_tdata[61:31];
                got_cmd.idx = i_s_tdata[67:62];
                got_cmd.wait_empty = 1'b0;
                expected_results.push_back(apply_cmd(got_cmd));
                n_accepted <= n_accepted + 1;
            end
        end
    end

    // Stimulus and end of test.
    initial begin
        int     kind;
        int     episode;
        int     slots;
        int     tmp;
        int     j;
        int     order [72];
        longint stride;
        longint span;
        longint maxlen;

        // Directed: empty read, zero lengths, front insert, append, touching merge,
        // extreme starts and lengths, out of range reads, clear.
        queue_read(0);
        queue_add(100, 0);
        queue_add(200, 50);
        queue_add(100, 0);
        queue_add(50, 10);
        queue_add(300, 10);
        queue_add(60, 40);
        queue_read(0);
        queue_read(1);
        queue_read(2);
        queue_add(0, 31'h7FFF_FFFF);
        queue_add(31'h7FFF_FFFF, 31'h7FFF_FFFF);
        queue_read(0);
        queue_read(63);
        queue_read(1);
        queue_clear();
        queue_read(0);
        queue_add(31'h7FFF_FFFF, 0);
        queue_add(0, 0);
        queue_read(1);
        queue_add(1, 31'h7FFF_FFFE);
        queue_read(0);
        queue_read(1);
        queue_clear();
        // The sender drains every response before this clear goes out.
        pending_cmds[pending_cmds.size() - 1].wait_empty = 1'b1;

        // Random episodes until the item budget is reached.
        episode = 0;
        while (pending_cmds.size() < TOTAL_ITEMS) begin
            kind = (episode == 0) ? 0 : $urandom_range(0, 9);
            if (kind <= 2) begin
                // Fill: disjoint ranges in shuffled order until the table overflows,
                // then reads and a few wide merges.
                queue_clear();
                if (episode % 3 == 1) pending_cmds[pending_cmds.size() - 1].wait_empty = 1'b1;
                slots = TABLE_DEPTH + $urandom_range(1, 8);
                stride = longint'(1) << $urandom_range(2, 24);
                for (int k = 0; k < slots; k++) order[k] = k;
                for (int k = slots - 1; k > 0; k--) begin
                    j = $urandom_range(0, k);
                    tmp = order[k];
                    order[k] = order[j];
                    order[j] = tmp;
                end
                for (int k = 0; k < slots; k++) begin
                    queue_add(order[k] * stride + $urandom_range(0, int'(stride / 4)),
                              $urandom_range(0, int'(stride / 4)));
                    if ($urandom_range(0, 9) == 0) queue_read($urandom_range(0, 63));
                end
                repeat (12) queue_read($urandom_range(0, 63));
                repeat (4) begin
                    queue_add({$urandom} % (slots * stride),
                              {$urandom} % (stride * $urandom_range(1, 8)));
                    queue_read($urandom_range(0, 63));
                end
            end else if (kind <= 6) begin
                // Dense: short ranges in a window of random size, mixed with reads and clears.
                span = longint'(1) << $urandom_range(6, 31);
                maxlen = span >> $urandom_range(3, 9);
                repeat ($urandom_range(20, 50)) begin
                    tmp = $urandom_range(0, 19);
                    if (tmp < 14) queue_add({$urandom} % span, {$urandom} % (maxlen + 1));
                    else if (tmp < 19) queue_read($urandom_range(0, 31));
                    else queue_clear();
                end
            end else if (kind <= 8) begin
                // Noise: any operation with fully random fields.
                repeat ($urandom_range(5, 15))
                    queue_cmd(2'($urandom_range(0, 2)), $urandom, $urandom,
                              $urandom_range(0, 63));
            end else begin
                repeat ($urandom_range(5, 20)) queue_read($urandom_range(0, 63));
            end
            episode++;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || i_s_tvalid) @(posedge i_clk);
        while (n_accepted != n_results) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatches == 0) begin
            $display("[sorted_range_merge_table_unit] OK");
        end else begin
            $display("[sorted_range_merge_table_unit] ERROR");
        end
        $finish;
    end

    // Watchdog for a hung run.
    initial begin
        #8_000_000;
        $display("[sorted_range_merge_table_unit] ERROR");
        $finish;
    end

endmodule
